FILE: hw/rtl/pmid_pkg.sv
// Shared widths and register codes of the periodic minimum-image distance unit.
package pmid_pkg;

  localparam int POS_W  = 24;
  localparam int COEF_W = 20;
  localparam int DIFF_W = 26;
  localparam int PROD_W = 46;
  localparam int ACC_W  = 48;
  localparam int MAG_W  = 30;
  localparam int SQ_W   = 62;
  localparam int ROOT_W = 31;
  localparam int REM_W  = 34;
  localparam int SCL_W  = 24;
  localparam int SPROD_W = 55;
  localparam int OUT_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [MAG_W-1:0] MAG_SAT = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_X = 2'd0,
    CFG_PERIOD_Y = 2'd1,
    CFG_PERIOD_Z = 2'd2,
    CFG_SCALE    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [POS_W-1:0]         first_x;
    logic [POS_W-1:0]         first_y;
    logic [POS_W-1:0]         first_z;
    logic [POS_W-1:0]         second_x;
    logic [POS_W-1:0]         second_y;
    logic [POS_W-1:0]         second_z;
    logic signed [COEF_W-1:0] coef_xx;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [COEF_W-1:0] coef_yx;
    logic signed [COEF_W-1:0] coef_yy;
    logic signed [COEF_W-1:0] coef_zz;
    logic                     cutoff_enable;
  } pmid_item_t;

  typedef struct packed {
    logic [POS_W-1:0] period_x;
    logic [POS_W-1:0] period_y;
    logic [POS_W-1:0] period_z;
  } pmid_period_t;

endpackage

FILE: hw/rtl/periodic_min_image_distance_unit.sv
// Top level of the periodic minimum-image distance unit.
// Each input beat on s_axis carries one atom pair: tdata holds the two
// positions and the five transform weights, tuser the cutoff enable. Each
// pair yields exactly one output beat on m_axis: tdata is the scaled
// distance in Q16.16, tuser is set when the cutoff is enabled and the
// transformed norm exceeds 1.7, in which case the distance is all ones.
// The box periods and the scale are written through the cfg port, whose
// ready is always high; write them only while no pair is in flight.
// From input beat to output beat a pair passes five stages for the wrap,
// transform and sum of squares, eight for the square root (four root
// bits per stage), one for the scale multiply and one for the output register.
// Throughput is one pair per cycle while m_axis_tready is high. When it is low,
// stages fill up behind the output register and empty slots are closed up, so
// s_axis_tready drops only once every stage holds a beat. Reset clears all
// valid bits and loads periods of 3.0 and a scale of 1.0.
module periodic_min_image_distance_unit import pmid_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [POS_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // coef_xx, coef_xy, coef_yx, coef_yy, coef_zz, then zero padding.
  input  logic [247:0]         s_axis_tdata,
  // cutoff_enable.
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // distance.
  output logic [OUT_W-1:0]     m_axis_tdata,
  // beyond_cutoff.
  output logic                 m_axis_tuser
);

  localparam logic [SPROD_W:0] HALF = (SPROD_W + 1)'(1) << (FRAC_BITS - 1);

  pmid_period_t      period_q;
  logic [SCL_W-1:0]  scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q.period_x <= POS_W'(3) << FRAC_BITS;
      period_q.period_y <= POS_W'(3) << FRAC_BITS;
      period_q.period_z <= POS_W'(3) << FRAC_BITS;
      scale_q           <= SCL_W'(1) << FRAC_BITS;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PERIOD_X: period_q.period_x <= cfg_data_i;
        CFG_PERIOD_Y: period_q.period_y <= cfg_data_i;
        CFG_PERIOD_Z: period_q.period_z <= cfg_data_i;
        CFG_SCALE:    scale_q           <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pmid_item_t item;
  assign item.first_x       = s_axis_tdata[23:0];
  assign item.first_y       = s_axis_tdata[47:24];
  assign item.first_z       = s_axis_tdata[71:48];
  assign item.second_x      = s_axis_tdata[95:72];
  assign item.second_y      = s_axis_tdata[119:96];
  assign item.second_z      = s_axis_tdata[143:120];
  assign item.coef_xx       = s_axis_tdata[163:144];
  assign item.coef_xy       = s_axis_tdata[183:164];
  assign item.coef_yx       = s_axis_tdata[203:184];
  assign item.coef_yy       = s_axis_tdata[223:204];
  assign item.coef_zz       = s_axis_tdata[243:224];
  assign item.cutoff_enable = s_axis_tuser;

  logic            fr_valid, fr_ready, fr_beyond;
  logic [SQ_W-1:0] fr_sumsq;

  pmid_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .period_i     (period_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (item),
    .out_valid_o  (fr_valid),
    .out_ready_i  (fr_ready),
    .out_sumsq_o  (fr_sumsq),
    .out_beyond_o (fr_beyond)
  );

  logic              sq_valid, sq_flag;
  logic [ROOT_W-1:0] sq_root;
  logic              en_m, en_o;

  pmid_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_value_i  (fr_sumsq),
    .in_flag_i   (fr_beyond),
    .out_valid_o (sq_valid),
    .out_ready_i (en_m),
    .out_root_o  (sq_root),
    .out_flag_o  (sq_flag)
  );

  logic               mv_q, ov_q;
  logic [SPROD_W-1:0] prod_q;
  logic               mflag_q;
  logic [OUT_W-1:0]   dist_q;
  logic               oflag_q;
  logic [SPROD_W:0]   rnd;

  assign en_o = !ov_q || m_axis_tready;
  assign en_m = !mv_q || en_o;
  assign rnd  = ((SPROD_W + 1)'(prod_q) + HALF) >> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en_m) mv_q <= sq_valid;
      if (en_o) ov_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m) begin
      prod_q  <= SPROD_W'(sq_root * scale_q);
      mflag_q <= sq_flag;
    end
    if (en_o) begin
      oflag_q <= mflag_q;
      if (mflag_q || (rnd[SPROD_W:OUT_W] != '0)) begin
        dist_q <= '1;
      end else begin
        dist_q <= rnd[OUT_W-1:0];
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = dist_q;
  assign m_axis_tuser  = oflag_q;

  a_beyond_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '1)
    else $error("flagged result without saturated distance");

  a_mult_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q && !en_m |=> mv_q && $stable(prod_q) && $stable(mflag_q))
    else $error("multiply stage lost its beat under stall");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !en_o |=> ov_q && $stable(dist_q))
    else $error("output register changed under stall");

endmodule

FILE: hw/rtl/pmid_front.sv
// Wrap, transform, rounding and sum-of-squares pipeline of five stages.
module pmid_front import pmid_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pmid_period_t     period_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pmid_item_t       in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SQ_W-1:0]  out_sumsq_o,
  output logic             out_beyond_o
);

  localparam logic [63:0] LIMIT = (64'd289 << (2 * FRAC_BITS)) / 64'd100;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic [4:0] v_q;
  logic [4:0] en;

  assign en[4] = !v_q[4] || out_ready_i;
  assign en[3] = !v_q[3] || en[4];
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
    end
  end

  function automatic logic signed [DIFF_W-1:0] wrap_axis(
    input logic [POS_W-1:0] a, input logic [POS_W-1:0] b, input logic [POS_W-1:0] p);
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] ps;
    logic signed [DIFF_W:0]   d2;
    logic signed [DIFF_W:0]   p2;
    d  = $signed({2'b00, b}) - $signed({2'b00, a});
    ps = $signed({2'b00, p});
    d2 = {d, 1'b0};
    p2 = $signed({3'b000, p});
    if (d2 > p2) begin
      d = d - ps;
    end else if (d2 < -p2) begin
      d = d + ps;
    end
    return d;
  endfunction

  function automatic logic [MAG_W-1:0] round_mag(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] r;
    m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    r = (m + HALF) >> FRAC_BITS;
    return (r > ACC_W'(MAG_SAT)) ? MAG_SAT : r[MAG_W-1:0];
  endfunction

  // Stage 1: displacement and minimum-image wrap.
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic signed [COEF_W-1:0] cxx_q, cxy_q, cyx_q, cyy_q, czz_q;
  logic en1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q  <= wrap_axis(in_item_i.first_x, in_item_i.second_x, period_i.period_x);
      dy_q  <= wrap_axis(in_item_i.first_y, in_item_i.second_y, period_i.period_y);
      dz_q  <= wrap_axis(in_item_i.first_z, in_item_i.second_z, period_i.period_z);
      cxx_q <= in_item_i.coef_xx;
      cxy_q <= in_item_i.coef_xy;
      cyx_q <= in_item_i.coef_yx;
      cyy_q <= in_item_i.coef_yy;
      czz_q <= in_item_i.coef_zz;
      en1_q <= in_item_i.cutoff_enable;
    end
  end

  // Stage 2: the five products.
  logic signed [PROD_W-1:0] pxx_q, pxy_q, pyx_q, pyy_q, pzz_q;
  logic en2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pxx_q <= PROD_W'(dx_q * cxx_q);
      pxy_q <= PROD_W'(dy_q * cxy_q);
      pyx_q <= PROD_W'(dx_q * cyx_q);
      pyy_q <= PROD_W'(dy_q * cyy_q);
      pzz_q <= PROD_W'(dz_q * czz_q);
      en2_q <= en1_q;
    end
  end

  // Stage 3: sums, rounding to the working fraction and saturation.
  logic [MAG_W-1:0] tx_q, ty_q, tz_q;
  logic en3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      tx_q  <= round_mag(ACC_W'(pxx_q) + ACC_W'(pxy_q));
      ty_q  <= round_mag(ACC_W'(pyx_q) + ACC_W'(pyy_q));
      tz_q  <= round_mag(ACC_W'(pzz_q));
      en3_q <= en2_q;
    end
  end

  // Stage 4: squares.
  logic [2*MAG_W-1:0] sx_q, sy_q, sz_q;
  logic en4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sx_q  <= tx_q * tx_q;
      sy_q  <= ty_q * ty_q;
      sz_q  <= tz_q * tz_q;
      en4_q <= en3_q;
    end
  end

  // Stage 5: sum of squares and the cutoff test.
  logic [SQ_W-1:0] sum_d;
  logic [SQ_W-1:0] sum_q;
  logic            beyond_q;

  assign sum_d = SQ_W'(sx_q) + SQ_W'(sy_q) + SQ_W'(sz_q);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      sum_q    <= sum_d;
      beyond_q <= en4_q && (64'(sum_d) > LIMIT);
    end
  end

  assign out_valid_o  = v_q[4];
  assign out_sumsq_o  = sum_q;
  assign out_beyond_o = beyond_q;

endmodule

FILE: hw/rtl/pmid_isqrt.sv
// Pipelined digit-by-digit integer square root, four root bits per stage.
module pmid_isqrt import pmid_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [SQ_W-1:0]   in_value_i,
  input  logic              in_flag_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ROOT_W-1:0] out_root_o,
  output logic              out_flag_o
);

  localparam int STEPS = 4;
  localparam int NSTG  = (ROOT_W + STEPS - 1) / STEPS;

  logic [NSTG-1:0]   v_q;
  logic [NSTG-1:0]   en;
  logic [SQ_W-1:0]   n_q    [NSTG];
  logic [REM_W-1:0]  rem_q  [NSTG];
  logic [ROOT_W-1:0] root_q [NSTG];
  logic              fl_q   [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic [SQ_W-1:0]   n_in, n_nx;
    logic [REM_W-1:0]  r_in, r_nx;
    logic [ROOT_W-1:0] q_in, q_nx;
    logic              v_in, f_in;

    if (k == 0) begin : g_first
      assign n_in = in_value_i;
      assign r_in = '0;
      assign q_in = '0;
      assign v_in = in_valid_i;
      assign f_in = in_flag_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = rem_q[k-1];
      assign q_in = root_q[k-1];
      assign v_in = v_q[k-1];
      assign f_in = fl_q[k-1];
    end

    if (k == NSTG - 1) begin : g_last
      assign en[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid
      assign en[k] = !v_q[k] || en[k+1];
    end

    always_comb begin
      logic [REM_W-1:0] r_try;
      logic [REM_W-1:0] trial;
      n_nx = n_in;
      r_nx = r_in;
      q_nx = q_in;
      for (int j = 0; j < STEPS; j++) begin
        if (k * STEPS + j < ROOT_W) begin
          r_try = {r_nx[REM_W-3:0], n_nx[SQ_W-1 -: 2]};
          trial = {1'b0, q_nx, 2'b01};
          n_nx  = {n_nx[SQ_W-3:0], 2'b00};
          if (r_try >= trial) begin
            r_nx = r_try - trial;
            q_nx = {q_nx[ROOT_W-2:0], 1'b1};
          end else begin
            r_nx = r_try;
            q_nx = {q_nx[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        n_q[k]    <= n_nx;
        rem_q[k]  <= r_nx;
        root_q[k] <= q_nx;
        fl_q[k]   <= f_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTG-1];
  assign out_root_o  = root_q[NSTG-1];
  assign out_flag_o  = fl_q[NSTG-1];

endmodule
